### rtl/core/bbpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bbpf_pkg;

  // frame geometry and memory sizes
  localparam int FULL_WIDTH      = 240;
  localparam int FULL_HEIGHT     = 160;
  localparam int REDUCED_WIDTH   = 160;
  localparam int REDUCED_HEIGHT  = 128;
  localparam int VIDEO_WORDS     = 40960;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAGE_HALFWORDS  = 20480;
  localparam int FRAC_BITS       = 8;

  localparam int POS_W  = 28;
  localparam int HALF_W = 16;

  localparam int DIM_MAX_W = (FULL_WIDTH > REDUCED_WIDTH) ? FULL_WIDTH : REDUCED_WIDTH;
  localparam int DIM_MAX_H = (FULL_HEIGHT > REDUCED_HEIGHT) ? FULL_HEIGHT : REDUCED_HEIGHT;
  localparam int DIM_MAX   = (DIM_MAX_W > DIM_MAX_H) ? DIM_MAX_W : DIM_MAX_H;
  // any coordinate at or above 2**COORD_W stays outside every frame after mosaic snap
  localparam int COORD_W   = $clog2(DIM_MAX + 16);
  localparam int CNT_W     = $clog2(COORD_W);
  localparam int LIN_W     = ((2 * COORD_W > 17) ? 2 * COORD_W : 17) + 1;
  localparam int VA_W      = $clog2(VIDEO_WORDS);
  localparam int PAL_W     = $clog2(PALETTE_ENTRIES);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // input kinds
  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_VWRITE = 2'd1;
  localparam logic [1:0] KIND_PWRITE = 2'd2;

  // bitmap modes
  localparam logic [1:0] MODE_FULL    = 2'd0;
  localparam logic [1:0] MODE_PAL     = 2'd1;
  localparam logic [1:0] MODE_REDUCED = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_PAGE     = 3'd1;
  localparam logic [2:0] REG_MOS_EN   = 3'd2;
  localparam logic [2:0] REG_MOS_W    = 3'd3;
  localparam logic [2:0] REG_MOS_H    = 3'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic       page;
    logic       mos_en;
    logic [3:0] mos_w;
    logic [3:0] mos_h;
  } cfg_t;

  // command passed from front to back; op uses the KIND_* codes
  typedef struct packed {
    logic [1:0]        op;
    logic              hit;       // lookup inside the frame
    logic              in_mem;    // lookup address inside video memory
    logic              paletted;
    logic              byte_hi;
    logic [VA_W-1:0]   addr;
    logic [HALF_W-1:0] data;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/bitmap_background_pixel_fetch.sv
// Channel  | Direction | Handshake                    | Payload
// s_axis   | in        | s_axis_tvalid / s_axis_tready | tuser kind, tdata coords + write
// m_axis   | out       | m_axis_tvalid / m_axis_tready | tuser visible, tdata colour
// cfg      | in        | cfg_we                        | cfg_index, cfg_data
//
// Front: a lookup runs the remainder unit, one bit per cycle, if mosaic is on and the
// position is not negative, then the calc and push states; memory writes go to push,
// dropped items back to idle. Back: a lookup may read video memory, then the palette.
// A two-entry queue separates front and back; a result in the output register holds
// back a lookup at the queue head, and the front stalls only once the queue is full.
// rst is synchronous and clears control state, not data registers or memories.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_background_pixel_fetch (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,   // pos_x[27:0], pos_y[55:28],
                                           // write_address[71:56], write_data[87:72]
  input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // pixel_color[15:0]
  output logic             m_axis_tuser,   // visible[0]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [3:0]  cfg_data
);

  bbpf_pkg::cfg_t cfg;
  logic           f_valid, f_ready, q_valid, q_ready;
  bbpf_pkg::cmd_t f_cmd, q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbpf_pkg::REG_MODE:   cfg.mode   <= cfg_data[1:0];
        bbpf_pkg::REG_PAGE:   cfg.page   <= cfg_data[0];
        bbpf_pkg::REG_MOS_EN: cfg.mos_en <= cfg_data[0];
        bbpf_pkg::REG_MOS_W:  cfg.mos_w  <= cfg_data;
        bbpf_pkg::REG_MOS_H:  cfg.mos_h  <= cfg_data;
        default: ;
      endcase
    end
  end

  bbpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_kind   (s_axis_tuser),
    .in_pos_x  (s_axis_tdata[27:0]),
    .in_pos_y  (s_axis_tdata[55:28]),
    .in_addr   (s_axis_tdata[71:56]),
    .in_data   (s_axis_tdata[87:72]),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bbpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .enq_valid (f_valid),
    .enq_ready (f_ready),
    .enq_data  (f_cmd),
    .deq_valid (q_valid),
    .deq_ready (q_ready),
    .deq_data  (q_cmd)
  );

  bbpf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_visible (m_axis_tuser),
    .out_color   (m_axis_tdata)
  );

  // front must hold its command while the queue is full
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid && $stable(f_cmd))
    else $error("front command changed while stalled");

  // an invisible pixel always carries colour zero
  a_invisible_black: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("invisible pixel with non-zero colour");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not empty after reset");

endmodule
`default_nettype wire

### rtl/core/bbpf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bbpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/bbpf_front.sv
`timescale 1ns / 1ps
`default_nettype none
module bbpf_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bbpf_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [bbpf_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic [bbpf_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic [bbpf_pkg::HALF_W-1:0]  in_addr,
  input  wire logic [bbpf_pkg::HALF_W-1:0]  in_data,
  output logic                              cmd_valid,
  input  wire logic                         cmd_ready,
  output bbpf_pkg::cmd_t                    cmd
);

  localparam int CW = bbpf_pkg::COORD_W;
  localparam int LW = bbpf_pkg::LIN_W;
  localparam int IW = bbpf_pkg::POS_W - 1 - bbpf_pkg::FRAC_BITS;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_CALC = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]             state;
  logic                   neg;
  logic                   big;
  logic [CW-1:0]          xr, yr, xsh, ysh;
  logic [3:0]             xrem, yrem;
  logic [bbpf_pkg::CNT_W-1:0] cnt;

  logic                   accept;
  logic [IW-1:0]          xi, yi;
  logic                   neg_next;
  logic [4:0]             nx, ny, tx, ty;
  logic [CW-1:0]          xs, ys, lim_w, lim_h;
  logic                   in_frame;
  logic [LW-1:0]          lin, full_addr;

  assign in_ready  = (state == F_IDLE);
  assign accept    = in_valid && in_ready;
  assign cmd_valid = (state == F_PUSH);

  assign xi       = in_pos_x[bbpf_pkg::POS_W-2:bbpf_pkg::FRAC_BITS];
  assign yi       = in_pos_y[bbpf_pkg::POS_W-2:bbpf_pkg::FRAC_BITS];
  assign neg_next = in_pos_x[bbpf_pkg::POS_W-1] | in_pos_y[bbpf_pkg::POS_W-1];

  // one restoring-remainder step per cycle, x and y side by side
  assign nx = {1'b0, cfg.mos_w} + 5'd1;
  assign ny = {1'b0, cfg.mos_h} + 5'd1;
  assign tx = {xrem, xsh[CW-1]};
  assign ty = {yrem, ysh[CW-1]};

  always_comb begin
    xs = xr - {{(CW-4){1'b0}}, xrem};
    ys = yr - {{(CW-4){1'b0}}, yrem};
    if (cfg.mode == bbpf_pkg::MODE_REDUCED) begin
      lim_w = CW'(bbpf_pkg::REDUCED_WIDTH);
      lim_h = CW'(bbpf_pkg::REDUCED_HEIGHT);
    end else begin
      lim_w = CW'(bbpf_pkg::FULL_WIDTH);
      lim_h = CW'(bbpf_pkg::FULL_HEIGHT);
    end
    in_frame = !neg && !big && (cfg.mode != bbpf_pkg::MODE_NONE) &&
               (xs < lim_w) && (ys < lim_h);
    // row length equals the frame width in every mode
    lin = (LW'(ys) * LW'(lim_w)) + LW'(xs);
    unique case (cfg.mode)
      bbpf_pkg::MODE_PAL:
        full_addr = (cfg.page ? LW'(2 * bbpf_pkg::PAGE_HALFWORDS) : '0) + lin;
      bbpf_pkg::MODE_REDUCED:
        full_addr = (cfg.page ? LW'(bbpf_pkg::PAGE_HALFWORDS) : '0) + lin;
      default:
        full_addr = lin;
    endcase
    // paletted: full_addr is a byte address, halve it for the halfword
    if (cfg.mode == bbpf_pkg::MODE_PAL) begin
      full_addr = full_addr >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            unique case (in_kind)
              bbpf_pkg::KIND_LOOKUP: begin
                state <= (cfg.mos_en && !neg_next) ? F_DIV : F_CALC;
              end
              bbpf_pkg::KIND_VWRITE: begin
                if ({16'd0, in_addr} < 32'(bbpf_pkg::VIDEO_WORDS)) begin
                  state <= F_PUSH;
                end
              end
              bbpf_pkg::KIND_PWRITE: begin
                if ({16'd0, in_addr} < 32'(bbpf_pkg::PALETTE_ENTRIES)) begin
                  state <= F_PUSH;
                end
              end
              default: ;
            endcase
          end
        end
        F_DIV: begin
          if (cnt == bbpf_pkg::CNT_W'(CW - 1)) begin
            state <= F_CALC;
          end
        end
        F_CALC: state <= F_PUSH;
        F_PUSH: begin
          if (cmd_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg  <= neg_next;
      big  <= (|xi[IW-1:CW]) | (|yi[IW-1:CW]);
      xr   <= xi[CW-1:0];
      yr   <= yi[CW-1:0];
      xsh  <= xi[CW-1:0];
      ysh  <= yi[CW-1:0];
      xrem <= '0;
      yrem <= '0;
      cnt  <= '0;
      cmd.op       <= in_kind;
      cmd.hit      <= 1'b0;
      cmd.in_mem   <= 1'b0;
      cmd.paletted <= 1'b0;
      cmd.byte_hi  <= 1'b0;
      cmd.addr     <= in_addr[bbpf_pkg::VA_W-1:0];
      cmd.data     <= in_data;
    end else if (state == F_DIV) begin
      xsh  <= xsh << 1;
      ysh  <= ysh << 1;
      xrem <= (tx >= nx) ? 4'(tx - nx) : tx[3:0];
      yrem <= (ty >= ny) ? 4'(ty - ny) : ty[3:0];
      cnt  <= cnt + 1'b1;
    end else if (state == F_CALC) begin
      cmd.hit      <= in_frame;
      cmd.in_mem   <= full_addr < LW'(bbpf_pkg::VIDEO_WORDS);
      cmd.paletted <= (cfg.mode == bbpf_pkg::MODE_PAL);
      cmd.byte_hi  <= lin[0];
      cmd.addr     <= full_addr[bbpf_pkg::VA_W-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/core/bbpf_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module bbpf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           enq_valid,
  output logic                enq_ready,
  input  wire bbpf_pkg::cmd_t enq_data,
  output logic                deq_valid,
  input  wire logic           deq_ready,
  output bbpf_pkg::cmd_t      deq_data
);

  localparam int PW = bbpf_pkg::QPTR_W;

  bbpf_pkg::cmd_t entries [bbpf_pkg::QDEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [PW:0]    count;
  logic           push, pop;

  assign enq_ready = (count != (PW + 1)'(bbpf_pkg::QDEPTH));
  assign deq_valid = (count != '0);
  assign deq_data  = entries[rptr];
  assign push      = enq_valid && enq_ready;
  assign pop       = deq_valid && deq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(bbpf_pkg::QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(bbpf_pkg::QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= enq_data;
    end
  end

endmodule
`default_nettype wire

### rtl/core/bbpf_back.sv
`timescale 1ns / 1ps
`default_nettype none
module bbpf_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_ready,
  input  wire bbpf_pkg::cmd_t              cmd,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_visible,
  output logic [bbpf_pkg::HALF_W-1:0]      out_color
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_VRD  = 2'd1;
  localparam logic [1:0] B_PRD  = 2'd2;

  logic [1:0]                    state;
  logic                          paletted, byte_hi;
  logic                          pop, is_lookup;
  logic [bbpf_pkg::HALF_W-1:0]   vdata, pdata;
  logic [bbpf_pkg::PAL_W-1:0]    idx;
  logic                          load;
  logic                          load_vis;
  logic [bbpf_pkg::HALF_W-1:0]   load_color;
  logic                          vram_re, pal_re;

  assign is_lookup = (cmd.op == bbpf_pkg::KIND_LOOKUP);
  // a lookup waits until the output register is free, writes do not wait for it
  assign cmd_ready = (state == B_IDLE) && (!is_lookup || !out_valid);
  assign pop       = cmd_valid && cmd_ready;
  assign vram_re   = pop && is_lookup && cmd.hit && cmd.in_mem;
  assign idx       = byte_hi ? vdata[15:8] : vdata[7:0];
  assign pal_re    = (state == B_VRD) && paletted && (idx != '0);

  bbpf_ram #(
    .WIDTH (bbpf_pkg::HALF_W),
    .DEPTH (bbpf_pkg::VIDEO_WORDS)
  ) u_vram (
    .clk   (clk),
    .we    (pop && (cmd.op == bbpf_pkg::KIND_VWRITE)),
    .waddr (cmd.addr),
    .wdata (cmd.data),
    .re    (vram_re),
    .raddr (cmd.addr),
    .rdata (vdata)
  );

  bbpf_ram #(
    .WIDTH (bbpf_pkg::HALF_W),
    .DEPTH (bbpf_pkg::PALETTE_ENTRIES)
  ) u_pal (
    .clk   (clk),
    .we    (pop && (cmd.op == bbpf_pkg::KIND_PWRITE)),
    .waddr (cmd.addr[bbpf_pkg::PAL_W-1:0]),
    .wdata (cmd.data),
    .re    (pal_re),
    .raddr (idx),
    .rdata (pdata)
  );

  always_comb begin
    load       = 1'b0;
    load_vis   = 1'b0;
    load_color = '0;
    unique case (state)
      B_IDLE: begin
        // miss, or address past the end of memory (reads as zero)
        if (pop && is_lookup && !(cmd.hit && cmd.in_mem)) begin
          load     = 1'b1;
          load_vis = cmd.hit && !cmd.paletted;
        end
      end
      B_VRD: begin
        if (!paletted) begin
          load       = 1'b1;
          load_vis   = 1'b1;
          load_color = vdata;
        end else if (idx == '0) begin
          load = 1'b1;  // transparent index
        end
      end
      B_PRD: begin
        load       = 1'b1;
        load_vis   = 1'b1;
        load_color = pdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE:  if (vram_re) state <= B_VRD;
        B_VRD:   state <= pal_re ? B_PRD : B_IDLE;
        B_PRD:   state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vram_re) begin
      paletted <= cmd.paletted;
      byte_hi  <= cmd.byte_hi;
    end
    if (load) begin
      out_visible <= load_vis;
      out_color   <= load_color;
    end
  end

endmodule
`default_nettype wire
